// ===== rtl/b64_pkg.sv =====
package b64_pkg;

  // Result status codes
  localparam logic [1:0] StData = 2'd0;
  localparam logic [1:0] StEnd  = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  // Pad character
  localparam logic [7:0] PadChar = 8'h3d;

  // Largest byte count shown on the result port
  localparam logic [15:0] MaxShown = 16'hffff;

  // Default width of the internal byte counter
  localparam int CountBitsDef = 16;

  // Result queue geometry
  localparam int QueueDepth = 8;
  localparam int PtrBits    = $clog2(QueueDepth);
  localparam int FillBits   = $clog2(QueueDepth + 1);

  // Most results one character can cause
  localparam int MaxPerChar = 3;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        last;
  } res_t;

  // Map one character onto its 6-bit alphabet value
  function automatic sextet_t sextet_of(logic [7:0] ch);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.val = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.val = 6'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.val = 6'(ch + 8'h04);
    end else if (ch == 8'h2b) begin
      s.val = 6'd62;
    end else if (ch == 8'h2f) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/b64_core.sv =====
module b64_core #(
  parameter int CountBits = b64_pkg::CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           character_i,
  input  logic                 first_i,
  output b64_pkg::res_t [2:0]  res_o,
  output logic [1:0]           res_num_o
);

  logic [1:0]           gpos_q, gpos_d;
  logic [17:0]          acc_q, acc_d;
  logic [1:0]           pad_q, pad_d;
  logic                 stop_q, stop_d;
  logic [CountBits-1:0] cnt_q, cnt_d;

  // Saturating counter step
  function automatic logic [CountBits-1:0] sat_inc(logic [CountBits-1:0] c);
    return (c == '1) ? c : c + CountBits'(1);
  endfunction

  // Counter as shown on the port, clamped to 16 bits
  function automatic logic [15:0] shown(logic [CountBits-1:0] c);
    return (c > CountBits'(b64_pkg::MaxShown)) ? b64_pkg::MaxShown : 16'(c);
  endfunction

  // Decode one character against the current group state
  always_comb begin
    logic [1:0]           g;
    logic [17:0]          a;
    logic [1:0]           p;
    logic                 s;
    logic [CountBits-1:0] c0, c1, c2, c3;
    logic [1:0]           pads;
    logic [23:0]          word;
    logic                 halt;
    b64_pkg::sextet_t     sx;

    g  = first_i ? 2'd0 : gpos_q;
    a  = first_i ? 18'd0 : acc_q;
    p  = first_i ? 2'd0 : pad_q;
    s  = first_i ? 1'b0 : stop_q;
    c0 = first_i ? '0 : cnt_q;
    c1 = sat_inc(c0);
    c2 = sat_inc(c1);
    c3 = sat_inc(c2);
    sx = b64_pkg::sextet_of(character_i);
    pads = p;
    word = {a, 6'd0};
    halt = 1'b0;

    gpos_d = g;
    acc_d  = a;
    pad_d  = p;
    stop_d = s;
    cnt_d  = c0;
    res_num_o = 2'd0;
    for (int i = 0; i < b64_pkg::MaxPerChar; i++) begin
      res_o[i].data_byte  = 8'd0;
      res_o[i].status     = b64_pkg::StData;
      res_o[i].byte_count = shown(c0);
      res_o[i].last       = 1'b0;
    end

    if (!s) begin
      case (g)
        2'd0: begin
          if (!sx.ok) begin
            res_o[0].status = b64_pkg::StEnd;
            res_o[0].last   = 1'b1;
            res_num_o = 2'd1;
            halt = 1'b1;
          end else begin
            acc_d  = {12'd0, sx.val};
            gpos_d = 2'd1;
          end
        end
        2'd1: begin
          if (!sx.ok) begin
            res_o[0].status = b64_pkg::StErr;
            res_o[0].last   = 1'b1;
            res_num_o = 2'd1;
            halt = 1'b1;
          end else begin
            acc_d  = {a[11:0], sx.val};
            gpos_d = 2'd2;
          end
        end
        2'd2: begin
          if (character_i == b64_pkg::PadChar) begin
            pad_d  = 2'd1;
            acc_d  = {a[11:0], 6'd0};
            gpos_d = 2'd3;
          end else if (!sx.ok) begin
            res_o[0].status = b64_pkg::StErr;
            res_o[0].last   = 1'b1;
            res_num_o = 2'd1;
            halt = 1'b1;
          end else begin
            acc_d  = {a[11:0], sx.val};
            gpos_d = 2'd3;
          end
        end
        default: begin
          if (character_i == b64_pkg::PadChar) begin
            pads = p + 2'd1;
          end else begin
            word = {a, sx.val};
          end
          if (character_i != b64_pkg::PadChar && (p != 2'd0 || !sx.ok)) begin
            res_o[0].status = b64_pkg::StErr;
            res_o[0].last   = 1'b1;
            res_num_o = 2'd1;
            halt = 1'b1;
          end else begin
            res_o[0].data_byte  = word[23:16];
            res_o[0].byte_count = shown(c1);
            case (pads)
              2'd0: begin
                // Full group: three bytes, go on with next group
                res_o[1].data_byte  = word[15:8];
                res_o[1].byte_count = shown(c2);
                res_o[2].data_byte  = word[7:0];
                res_o[2].byte_count = shown(c3);
                res_o[2].last       = 1'b1;
                res_num_o = 2'd3;
                cnt_d  = c3;
                gpos_d = 2'd0;
                acc_d  = 18'd0;
                pad_d  = 2'd0;
              end
              2'd1: begin
                res_o[1].data_byte  = word[15:8];
                res_o[1].byte_count = shown(c2);
                res_o[2].status     = b64_pkg::StEnd;
                res_o[2].byte_count = shown(c2);
                res_o[2].last       = 1'b1;
                res_num_o = 2'd3;
                cnt_d = c2;
                halt  = 1'b1;
              end
              default: begin
                res_o[1].status     = b64_pkg::StEnd;
                res_o[1].byte_count = shown(c1);
                res_o[1].last       = 1'b1;
                res_num_o = 2'd2;
                cnt_d = c1;
                halt  = 1'b1;
              end
            endcase
          end
        end
      endcase
    end

    // Stop the string and clear the group
    if (halt) begin
      stop_d = 1'b1;
      gpos_d = 2'd0;
      acc_d  = 18'd0;
      pad_d  = 2'd0;
    end
  end

  // Advance group state on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpos_q <= 2'd0;
      acc_q  <= 18'd0;
      pad_q  <= 2'd0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      gpos_q <= gpos_d;
      acc_q  <= acc_d;
      pad_q  <= pad_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/base64_decoder.sv =====
// Streaming base64 text decoder. One character is taken per cycle while
// in_stall_o is low; the fourth character of a group yields up to three
// results (bytes, then an end mark after a pad), and a bad character yields
// one end or error mark. Results leave an eight-entry queue one per cycle
// while out_stall_i is low, and enter it the cycle after their character is
// taken. in_stall_o rises while fewer than three queue slots are free.
// A request with first_i set starts a new string; after an end, an error or
// a pad group, characters are dropped until the next such request.
module base64_decoder #(
  parameter int CountBits = b64_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] byte_count_o,
  output logic        last_o
);

  localparam int PtrBits  = b64_pkg::PtrBits;
  localparam int FillBits = b64_pkg::FillBits;

  b64_pkg::res_t [2:0] res;
  logic [1:0]          res_num;
  logic                accept, pop;

  b64_pkg::res_t       queue_q [b64_pkg::QueueDepth];
  logic [PtrBits-1:0]  wr_q, rd_q;
  logic [FillBits-1:0] fill_q, fill_d;

  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = fill_q > FillBits'(b64_pkg::QueueDepth - b64_pkg::MaxPerChar);

  b64_core #(
    .CountBits(CountBits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .character_i(character_i),
    .first_i    (first_i),
    .res_o      (res),
    .res_num_o  (res_num)
  );

  // Push new results into the queue
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < b64_pkg::MaxPerChar; i++) begin
        if (2'(i) < res_num) begin
          queue_q[wr_q + PtrBits'(i)] <= res[i];
        end
      end
    end
  end

  assign fill_d = fill_q + (accept ? FillBits'(res_num) : FillBits'(0))
                  - FillBits'(pop);

  // Advance queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (accept) begin
        wr_q <= wr_q + PtrBits'(res_num);
      end
      if (pop) begin
        rd_q <= rd_q + PtrBits'(1);
      end
      fill_q <= fill_d;
    end
  end

  // Show the oldest result
  assign out_valid_o  = fill_q != '0;
  assign data_byte_o  = queue_q[rd_q].data_byte;
  assign status_o     = queue_q[rd_q].status;
  assign byte_count_o = queue_q[rd_q].byte_count;
  assign last_o       = queue_q[rd_q].last;

  // Queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillBits'(b64_pkg::QueueDepth))
    else $error("result queue overflow");

  // A request that causes results shows one next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_num != 2'd0) |=> out_valid_o)
    else $error("results lost after request");

  // End and error marks always close their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != b64_pkg::StData) |-> last_o)
    else $error("end or error mark not last");

  // A data byte is always counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == b64_pkg::StData) |-> byte_count_o != 16'd0)
    else $error("data byte with zero count");

endmodule

// ===== tb/testbench.sv =====
module testbench;

  // Clock, reset and DUT ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = 8'h00;
  logic        first_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic [1:0]  status_o;
  logic [15:0] byte_count_o;
  logic        last_o;

  base64_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .character_i  (character_i),
    .first_i      (first_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  // One character request waiting to be driven
  typedef struct {
    logic [7:0] ch;
    logic       first;
    bit         hold;
  } char_req_t;

  char_req_t        pending_chars[$];
  b64_pkg::res_t    expected_results[$];

  int mismatches = 0;
  int queued     = 0;
  bit fresh      = 1'b0;
  bit hold_next  = 1'b0;
  bit idle_on    = 1'b1;

  // Decoder state as the predictor sees it
  logic [1:0]  grp_pos = '0;
  logic [17:0] acc     = '0;
  logic        pad3    = 1'b0;
  logic        halted  = 1'b0;
  logic [15:0] nbytes  = '0;

  // Base64 alphabet: value to character
  function automatic logic [7:0] b64_char(int v);
    if (v < 26) return 8'(65 + v);
    if (v < 52) return 8'(97 + v - 26);
    if (v < 62) return 8'(48 + v - 52);
    if (v == 62) return 8'h2b;
    return 8'h2f;
  endfunction

  // Character to value, -1 when outside the alphabet
  function automatic int digit_value(logic [7:0] ch);
    for (int i = 0; i < 64; i++) begin
      if (b64_char(i) == ch) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] rand_digit();
    return b64_char($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_junk();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (digit_value(ch) >= 0) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  task automatic emit(logic [7:0] d, logic [1:0] st);
    b64_pkg::res_t r;
    r.data_byte  = d;
    r.status     = st;
    r.byte_count = nbytes;
    r.last       = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic emit_byte(logic [7:0] d);
    if (nbytes != 16'hffff) nbytes++;
    emit(d, b64_pkg::StData);
  endtask

  // Work out the results that one accepted character causes
  task automatic decode_char(logic [7:0] ch, logic fst);
    int            v;
    int            n;
    int            pads;
    bit            bad;
    logic [23:0]   word;
    b64_pkg::res_t r;
    n = expected_results.size();
    if (fst) begin
      grp_pos = '0;
      acc     = '0;
      pad3    = 1'b0;
      halted  = 1'b0;
      nbytes  = '0;
    end
    if (halted) return;
    v    = digit_value(ch);
    bad  = 1'b0;
    word = '0;
    case (grp_pos)
      2'd0: begin
        if (v < 0) begin
          emit(8'h00, b64_pkg::StEnd);
          halted = 1'b1;
        end else begin
          acc     = 18'(v);
          grp_pos = 2'd1;
        end
      end
      2'd1: begin
        if (v < 0) begin
          emit(8'h00, b64_pkg::StErr);
          halted  = 1'b1;
          grp_pos = '0;
        end else begin
          acc     = {acc[11:0], 6'(v)};
          grp_pos = 2'd2;
        end
      end
      2'd2: begin
        if (ch == b64_pkg::PadChar) begin
          pad3    = 1'b1;
          acc     = {acc[11:0], 6'd0};
          grp_pos = 2'd3;
        end else if (v < 0) begin
          emit(8'h00, b64_pkg::StErr);
          halted  = 1'b1;
          grp_pos = '0;
        end else begin
          acc     = {acc[11:0], 6'(v)};
          grp_pos = 2'd3;
        end
      end
      default: begin
        pads = pad3 ? 1 : 0;
        if (ch == b64_pkg::PadChar) begin
          pads++;
          word = {acc, 6'd0};
        end else if (pads != 0 || v < 0) begin
          bad = 1'b1;
        end else begin
          word = {acc, 6'(v)};
        end
        if (bad) begin
          emit(8'h00, b64_pkg::StErr);
          halted = 1'b1;
        end else begin
          emit_byte(word[23:16]);
          if (pads < 2) emit_byte(word[15:8]);
          if (pads < 1) emit_byte(word[7:0]);
          if (pads != 0) begin
            emit(8'h00, b64_pkg::StEnd);
            halted = 1'b1;
          end
        end
        grp_pos = '0;
        acc     = '0;
        pad3    = 1'b0;
      end
    endcase
    // Flag the final result of this character
    if (expected_results.size() > n) begin
      r = expected_results.pop_back();
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  // Stimulus helpers
  task automatic push_char(logic [7:0] ch);
    char_req_t q;
    q.ch      = ch;
    q.first   = fresh;
    q.hold    = hold_next;
    fresh     = 1'b0;
    hold_next = 1'b0;
    pending_chars.push_back(q);
    queued++;
  endtask

  task automatic push_text(string s);
    fresh = 1'b1;
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // One string: full groups, then one of several ways to finish it
  task automatic random_string();
    int groups;
    int ending;
    int n0;
    fresh  = 1'b1;
    groups = $urandom_range(0, 3);
    ending = $urandom_range(0, 7);
    repeat (groups) repeat (4) push_char(rand_digit());
    case (ending)
      0: push_char(8'h00);
      1: begin
        repeat (3) push_char(rand_digit());
        push_char(b64_pkg::PadChar);
      end
      2: begin
        repeat (2) push_char(rand_digit());
        push_char(b64_pkg::PadChar);
        push_char(b64_pkg::PadChar);
      end
      3: push_char(rand_junk());
      5: begin
        repeat ($urandom_range(1, 3)) push_char(rand_digit());
        push_char(rand_junk());
      end
      6: begin
        repeat (2) push_char(rand_digit());
        push_char(b64_pkg::PadChar);
        push_char($urandom_range(0, 1) ? rand_digit() : rand_junk());
      end
      7: repeat ($urandom_range(1, 3)) push_char(rand_digit());
      default: ;
    endcase
    // Trailing characters that a stopped decoder drops
    if (ending != 4 && ending != 7 && $urandom_range(0, 1) == 1) begin
      n0 = queued;
      repeat ($urandom_range(1, 2)) push_char(8'($urandom_range(0, 255)));
      queued = n0;
    end
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Alternate stretches with and without idling
  bit calm      = 1'b0;
  int calm_left = 0;
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(20, 80);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Driver: predict accepted requests, then present the next one
  int        gap_left = 0;
  char_req_t cur;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_char(character_i, first_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() == 0 ||
                     (pending_chars[0].hold && expected_results.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          cur = pending_chars.pop_front();
          character_i <= cur.ch;
          first_i     <= cur.first;
          in_valid_i  <= 1'b1;
          if (idle_on && !calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 7);
        end
      end
    end
  end

  // Monitor: compare each accepted result, then decide the next stall
  int            stall_left = 0;
  b64_pkg::res_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", status_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (data_byte_o !== want.data_byte)
            report_mismatch("data_byte", data_byte_o, want.data_byte);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (byte_count_o !== want.byte_count)
            report_mismatch("byte_count", byte_count_o, want.byte_count);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("FAIL base64_decoder");
    $finish;
  end

  // Sequence the phases of the run
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme values, several ways a string finishes
    push_text("////AAAA");
    push_char(8'h00);
    push_text("TQ==");
    push_char("A");
    push_text("TWE=");
    push_text("T=");
    push_text("TW=x");
    fresh = 1'b1;
    push_char(b64_pkg::PadChar);
    drain();

    // Random strings; the first request waits for an empty pipeline
    queued    = 0;
    hold_next = 1'b1;
    while (queued < 160) random_string();
    drain();

    // Closing stretch without idling
    idle_on = 1'b0;
    repeat (8) random_string();
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS base64_decoder");
    end else begin
      $display("FAIL base64_decoder");
    end
    $finish;
  end

endmodule
